// ===== hw/rtl/ipmbrr_pkg.sv =====
// Package: event and result types and codes for the IPMB response receiver.
package ipmbrr_pkg;

  // Event kinds from the I2C slave side
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Frame verdicts
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_NOT_RESP  = 2'd2;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd3;

  // netfn bit that marks a response
  localparam logic [7:0] RESPONSE_BIT = 8'h04;

  // Frame positions of the captured header bytes
  localparam int POS_NETFN      = 0;
  localparam int POS_SEQ        = 3;
  localparam int POS_COMMAND    = 4;
  localparam int POS_COMPLETION = 5;

  // Header and trailer bytes around the payload
  localparam int FRAME_OVERHEAD = 5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } event_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [6:0] byte_position;
    logic       frame_done;
    logic [1:0] status;
    logic [6:0] frame_length;
    logic [7:0] netfn_byte;
    logic [5:0] sequence_number;
    logic [7:0] command;
    logic [7:0] compl_code;
  } result_t;

endpackage

// ===== hw/rtl/ipmbrr_frame.sv =====
// Frame state: byte count, running checksum, captured header bytes and verdict.
module ipmbrr_frame #(
  parameter int PAYLOAD_BYTES      = 122,
  parameter int MIN_RESPONSE_BYTES = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  ipmbrr_pkg::event_t     evt,
  input  logic [6:0]             own_address,
  output ipmbrr_pkg::result_t    result
);

  localparam int FRAME_BYTES = PAYLOAD_BYTES + ipmbrr_pkg::FRAME_OVERHEAD;
  localparam int CW          = $clog2(FRAME_BYTES + 1);
  localparam int XW          = CW + 7;

  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic [7:0]    running_sum;
  logic [7:0]    running_sum_next;
  logic [7:0]    held_netfn;
  logic [7:0]    held_netfn_next;
  logic [7:0]    held_seq_byte;
  logic [7:0]    held_seq_byte_next;
  logic [7:0]    held_command;
  logic [7:0]    held_command_next;
  logic [7:0]    held_completion;
  logic [7:0]    held_completion_next;

  logic [XW-1:0] count_ext;
  logic          frame_full;
  logic          too_short;
  logic [7:0]    seed;

  assign count_ext  = {7'd0, byte_count};
  assign frame_full = (byte_count >= CW'(FRAME_BYTES));
  assign too_short  = (count_ext < XW'(MIN_RESPONSE_BYTES));
  assign seed       = {own_address, 1'b0};

  // Next state and result for the current event
  always_comb begin
    byte_count_next      = byte_count;
    running_sum_next     = running_sum;
    held_netfn_next      = held_netfn;
    held_seq_byte_next   = held_seq_byte;
    held_command_next    = held_command;
    held_completion_next = held_completion;
    result               = '0;
    case (evt.mode)
      ipmbrr_pkg::MODE_START: begin
        byte_count_next      = '0;
        running_sum_next     = seed;
        held_netfn_next      = '0;
        held_seq_byte_next   = '0;
        held_command_next    = '0;
        held_completion_next = '0;
      end
      ipmbrr_pkg::MODE_BYTE: begin
        if (!frame_full) begin
          if (count_ext == XW'(ipmbrr_pkg::POS_NETFN))      held_netfn_next      = evt.data_byte;
          if (count_ext == XW'(ipmbrr_pkg::POS_SEQ))        held_seq_byte_next   = evt.data_byte;
          if (count_ext == XW'(ipmbrr_pkg::POS_COMMAND))    held_command_next    = evt.data_byte;
          if (count_ext == XW'(ipmbrr_pkg::POS_COMPLETION)) held_completion_next = evt.data_byte;
          running_sum_next     = running_sum + evt.data_byte;
          byte_count_next      = byte_count + 1'b1;
          result.byte_valid    = 1'b1;
          result.byte_value    = evt.data_byte;
          result.byte_position = count_ext[6:0];
        end
      end
      ipmbrr_pkg::MODE_STOP: begin
        result.frame_done = 1'b1;
        if (too_short) begin
          result.status = ipmbrr_pkg::STATUS_SHORT;
        end else if ((held_netfn & ipmbrr_pkg::RESPONSE_BIT) == 8'd0) begin
          result.status = ipmbrr_pkg::STATUS_NOT_RESP;
        end else if (running_sum != 8'd0) begin
          result.status = ipmbrr_pkg::STATUS_CHECKSUM;
        end else begin
          result.status = ipmbrr_pkg::STATUS_OK;
        end
        result.frame_length    = count_ext[6:0];
        result.netfn_byte      = held_netfn;
        result.sequence_number = held_seq_byte[7:2];
        result.command         = held_command;
        result.compl_code      = held_completion;
        // frame restarts after the verdict
        byte_count_next      = '0;
        running_sum_next     = seed;
        held_netfn_next      = '0;
        held_seq_byte_next   = '0;
        held_command_next    = '0;
        held_completion_next = '0;
      end
      default: begin
        // unused event code: no state change
      end
    endcase
  end

  // State update on each accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_sum     <= '0;
      held_netfn      <= '0;
      held_seq_byte   <= '0;
      held_command    <= '0;
      held_completion <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      running_sum     <= running_sum_next;
      held_netfn      <= held_netfn_next;
      held_seq_byte   <= held_seq_byte_next;
      held_command    <= held_command_next;
      held_completion <= held_completion_next;
    end
  end

endmodule

// ===== hw/rtl/ipmb_response_receiver_core.sv =====
// Top level: IPMB response receiver with event input, result register and config port.
//
//  channel | signals                     | direction | transaction
//  --------+-----------------------------+-----------+-----------------------------
//  evt     | evt_valid, evt_stall, evt   | in        | valid && !stall
//  res     | res_valid, res_stall, res   | out       | valid && !stall
//  cfg     | cfg_valid, cfg_ready, cfg_data | in     | valid && ready (own address)
//
// Frame state updates at acceptance and the event's result lands in the result
// register, one result per event, one event per cycle while res is not stalled.
// Throughput is set by the single result register; a new event is taken
// whenever that register is empty or being drained in the same cycle.
// While res is stalled with a result held, evt_stall is high.
// Synchronous reset clears the frame state, own address and result valid.
module ipmb_response_receiver_core #(
  parameter int PAYLOAD_BYTES      = 122,
  parameter int MIN_RESPONSE_BYTES = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                evt_valid,
  output logic                evt_stall,
  input  ipmbrr_pkg::event_t  evt,
  output logic                res_valid,
  input  logic                res_stall,
  output ipmbrr_pkg::result_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  logic                accept;
  logic [6:0]          own_address;
  ipmbrr_pkg::result_t result;

  assign evt_stall = res_valid && res_stall;
  assign accept    = evt_valid && !evt_stall;
  assign cfg_ready = 1'b1;

  // Own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  ipmbrr_frame #(
    .PAYLOAD_BYTES      (PAYLOAD_BYTES),
    .MIN_RESPONSE_BYTES (MIN_RESPONSE_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .evt         (evt),
    .own_address (own_address),
    .result      (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= result;
    end
  end

  // Checks
  a_no_accept_when_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |-> !accept)
    else $error("event accepted while result held");

  a_stop_no_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_done) |-> !res.byte_valid)
    else $error("stop result also carries a byte");

  a_status_only_on_stop: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.frame_done) |-> (res.status == ipmbrr_pkg::STATUS_OK))
    else $error("status set without frame done");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted event produced no result");

endmodule
